[design/hmsct_pkg.sv]
// Shared constants for the hours:minutes:seconds countdown timer.
// Operation and key codes, field limits and the result word layout.
// No dependencies.
`default_nettype none

package hmsct_pkg;

	// Operation codes carried in the request tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_KEY   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Decoded keypad codes
	localparam logic [3:0] KEY_PLUS  = 4'd1;
	localparam logic [3:0] KEY_LEFT  = 4'd4;
	localparam logic [3:0] KEY_START = 4'd5;
	localparam logic [3:0] KEY_RIGHT = 4'd6;
	localparam logic [3:0] KEY_MINUS = 4'd9;
	localparam logic [3:0] KEY_MODE  = 4'd15;

	// Configuration register indexes
	localparam logic CFG_TICKS_PER_SECOND = 1'b0;
	localparam logic CFG_WARNING_SECONDS  = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd100;
	localparam logic [6:0] WARNING_SECONDS_RST  = 7'd5;

	// Field limits
	localparam logic [6:0] FIELD_MAX    = 7'd99;
	localparam logic [6:0] FIELD_OVER   = 7'd100;
	localparam logic [6:0] SIXTY_MINUS1 = 7'd59;

	// Selected field codes
	localparam logic [1:0] SEL_SEC  = 2'd0;
	localparam logic [1:0] SEL_MIN  = 2'd1;
	localparam logic [1:0] SEL_HOUR = 2'd2;

	// Result word layout
	localparam int OUT_W       = 32;
	localparam int SEC_LSB     = 0;
	localparam int MIN_LSB     = 7;
	localparam int HOUR_LSB    = 14;
	localparam int RUN_BIT     = 21;
	localparam int SEL_LSB     = 22;
	localparam int MODE_BIT    = 24;
	localparam int RELAY_BIT   = 25;
	localparam int ALARM_BIT   = 26;
	localparam int FINISH_BIT  = 27;

endpackage

`default_nettype wire

[design/hms_countdown_timer.sv]
// Hours:minutes:seconds countdown timer with prescaler and keypad editing.
// A request is captured in the input stage, then its result is registered for m_axis.
// Throughput: one request per cycle unless stalled; state update is a single pass of
// prescale compare, borrow and field wrap logic between input and result registers.
// Reset: arst_n clears time, prescaler, flags and pipeline valids at once and
// loads ticks_per_second = 100, warning_seconds = 5.
// Depends on hmsct_pkg.
`default_nettype none

module hms_countdown_timer
	import hmsct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [3:0] key, [7:4] zero
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // [6:0] seconds, [13:7] minutes,
	                                         // [20:14] hours, [21] running,
	                                         // [23:22] selected_field, [24] mode_led,
	                                         // [25] relay_on, [26] alarm,
	                                         // [27] finished, [31:28] zero
);

	// configuration registers
	logic [7:0] ticks_per_second_q;
	logic [6:0] warning_seconds_q;

	// timer state
	logic [7:0] prescale_q;
	logic [6:0] sec_q, min_q, hour_q;
	logic       run_q;
	logic [1:0] sel_q;
	logic       mode_q;

	// input stage
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [3:0] key_s1;

	// result register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic advance;

	// next state
	logic [7:0] nx_prescale;
	logic [6:0] nx_sec, nx_min, nx_hour;
	logic       nx_run, nx_mode, nx_finished, nx_alarm;
	logic [1:0] nx_sel;

	// Move the input stage forward when the result register is free or drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q <= TICKS_PER_SECOND_RST;
			warning_seconds_q  <= WARNING_SECONDS_RST;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_TICKS_PER_SECOND) begin
				ticks_per_second_q <= cfg_wdata;
			end else begin
				warning_seconds_q <= cfg_wdata[6:0];
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1  <= s_axis_tuser;
			key_s1 <= s_axis_tdata[3:0];
		end
	end

	// Compute the state after the staged request
	always_comb begin
		logic [8:0] tick_next;
		logic [6:0] field;
		logic [6:0] field_new;
		tick_next   = {1'b0, prescale_q} + 9'd1;
		nx_prescale = prescale_q;
		nx_sec      = sec_q;
		nx_min      = min_q;
		nx_hour     = hour_q;
		nx_run      = run_q;
		nx_sel      = sel_q;
		nx_mode     = mode_q;
		nx_finished = 1'b0;

		// edited field: a select code of three edits hours
		if (sel_q == SEL_SEC) begin
			field = sec_q;
		end else if (sel_q == SEL_MIN) begin
			field = min_q;
		end else begin
			field = hour_q;
		end
		field_new = field;

		case (op_s1)
			OP_TICK: begin
				if (tick_next >= {1'b0, ticks_per_second_q}) begin
					nx_prescale = '0;
					// one second elapses: count down with borrow
					if (run_q) begin
						if (sec_q != '0) begin
							nx_sec = sec_q - 7'd1;
						end else if (min_q != '0) begin
							nx_min = min_q - 7'd1;
							nx_sec = SIXTY_MINUS1;
						end else if (hour_q != '0) begin
							nx_hour = hour_q - 7'd1;
							nx_min  = SIXTY_MINUS1;
							nx_sec  = SIXTY_MINUS1;
						end
					end
				end else begin
					nx_prescale = tick_next[7:0];
				end
			end
			OP_KEY: begin
				if (!run_q) begin
					unique case (key_s1)
						KEY_START: nx_run = 1'b1;
						KEY_LEFT:  nx_sel = (sel_q >= SEL_HOUR) ? SEL_SEC : sel_q + 2'd1;
						KEY_RIGHT: nx_sel = (sel_q == SEL_SEC || sel_q > SEL_HOUR) ?
						                    SEL_HOUR : sel_q - 2'd1;
						KEY_PLUS:  field_new = (field >= FIELD_MAX) ? 7'd0 : field + 7'd1;
						KEY_MINUS: begin
							if (field == '0 || field > FIELD_OVER) begin
								field_new = FIELD_MAX;
							end else begin
								field_new = field - 7'd1;
							end
						end
						KEY_MODE:  nx_mode = !mode_q;
						default:   ;
					endcase
					if (sel_q == SEL_SEC) begin
						nx_sec = field_new;
					end else if (sel_q == SEL_MIN) begin
						nx_min = field_new;
					end else begin
						nx_hour = field_new;
					end
				end
			end
			OP_CLEAR: begin
				nx_sec  = '0;
				nx_min  = '0;
				nx_hour = '0;
			end
			default: ;
		endcase

		// Stop at zero, toggle the mode and flag the finish
		if (nx_run && nx_sec == '0 && nx_min == '0 && nx_hour == '0) begin
			nx_run      = 1'b0;
			nx_mode     = !nx_mode;
			nx_finished = 1'b1;
		end

		nx_alarm = nx_run && nx_hour == '0 && nx_min == '0 &&
		           nx_sec < warning_seconds_q;
	end

	// Commit the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			sec_q      <= '0;
			min_q      <= '0;
			hour_q     <= '0;
			run_q      <= 1'b0;
			sel_q      <= SEL_SEC;
			mode_q     <= 1'b0;
		end else if (advance) begin
			prescale_q <= nx_prescale;
			sec_q      <= nx_sec;
			min_q      <= nx_min;
			hour_q     <= nx_hour;
			run_q      <= nx_run;
			sel_q      <= nx_sel;
			mode_q     <= nx_mode;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'd0, nx_finished, nx_alarm, !nx_mode, nx_mode, nx_sel,
			               nx_run, nx_hour, nx_min, nx_sec};
		end
	end

endmodule

`default_nettype wire

[design/hms_countdown_timer_chk.sv]
// Port-level checks for the countdown timer result stream.
// Depends on hmsct_pkg; bound to hms_countdown_timer.
`default_nettype none

module hms_countdown_timer_chk
	import hmsct_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	// Relay always drives the inverse of the mode indicator
	a_relay: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[RELAY_BIT] != m_axis_tdata[MODE_BIT]))
		else $error("relay_on is not the inverse of mode_led");

	// Finishing stops the count with all fields at zero
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[FINISH_BIT]) |->
		(!m_axis_tdata[RUN_BIT] && m_axis_tdata[HOUR_LSB+6:SEC_LSB] == '0))
		else $error("finished with time left or still running");

	// Alarm only while running in the last minute of the last hour
	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[ALARM_BIT]) |->
		(m_axis_tdata[RUN_BIT] && m_axis_tdata[HOUR_LSB+6:MIN_LSB] == '0))
		else $error("alarm raised outside the final seconds");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind hms_countdown_timer hms_countdown_timer_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the hours:minutes:seconds countdown timer.
// Drives tick, key and clear requests and checks every result word.
// Depends on hmsct_pkg and hms_countdown_timer.

module tb;
	import hmsct_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [3:0] KEY_NONE  = 4'd0;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_addr;
	logic [7:0]        cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;   // [3:0] key, [7:4] zero
	logic [1:0]        s_axis_tuser;   // [1:0] operation
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;   // [6:0] sec, [13:7] min, [20:14] hour, [21] running,
	                                   // [23:22] field, [24] mode, [25] relay, [26] alarm,
	                                   // [27] finished, [31:28] zero

	int idle_pct;
	int accepted;

	typedef struct {
		logic [6:0] sec;
		logic [6:0] min;
		logic [6:0] hour;
		logic       running;
		logic [1:0] field;
		logic       mode;
		logic       relay;
		logic       alarm;
		logic       finished;
	} timer_status_t;

	// Timer model plus the store of status words still owed by the block
	class timer_scoreboard;
		logic [7:0]    tps_reg;
		logic [6:0]    warn_reg;
		logic [7:0]    prescale;
		logic [6:0]    sec_v;
		logic [6:0]    min_v;
		logic [6:0]    hour_v;
		logic          run_flag;
		logic [1:0]    field_sel;
		logic          mode_flag;
		timer_status_t status_q[$];
		int            errors;

		function new();
			tps_reg   = TICKS_PER_SECOND_RST;
			warn_reg  = WARNING_SECONDS_RST;
			prescale  = '0;
			sec_v     = '0;
			min_v     = '0;
			hour_v    = '0;
			run_flag  = 1'b0;
			field_sel = SEL_SEC;
			mode_flag = 1'b0;
			errors    = 0;
		endfunction

		function void write_reg(logic idx, logic [7:0] val);
			if (idx == CFG_TICKS_PER_SECOND) tps_reg = val;
			else warn_reg = val[6:0];
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		// Advance the timer by one request and queue the status it leaves
		function void note_request(logic [1:0] op, logic [3:0] key);
			logic [8:0]    nxt;
			logic [6:0]    val;
			timer_status_t st;
			st.finished = 1'b0;
			case (op)
				OP_TICK: begin
					nxt = {1'b0, prescale} + 9'd1;
					if (nxt >= {1'b0, tps_reg}) begin
						prescale = '0;
						// borrow down through seconds, minutes, hours
						if (run_flag) begin
							if (sec_v != 0) begin
								sec_v = sec_v - 7'd1;
							end else if (min_v != 0) begin
								min_v = min_v - 7'd1;
								sec_v = SIXTY_MINUS1;
							end else if (hour_v != 0) begin
								hour_v = hour_v - 7'd1;
								min_v  = SIXTY_MINUS1;
								sec_v  = SIXTY_MINUS1;
							end
						end
					end else begin
						prescale = nxt[7:0];
					end
				end
				OP_KEY: begin
					if (!run_flag) begin
						val = (field_sel == SEL_SEC) ? sec_v :
						      (field_sel == SEL_MIN) ? min_v : hour_v;
						case (key)
							KEY_START: run_flag = 1'b1;
							KEY_LEFT:  field_sel = (field_sel >= SEL_HOUR) ? SEL_SEC :
							                       field_sel + 2'd1;
							KEY_RIGHT: field_sel = (field_sel == SEL_SEC || field_sel > SEL_HOUR) ?
							                       SEL_HOUR : field_sel - 2'd1;
							KEY_PLUS:  val = (val >= FIELD_MAX) ? 7'd0 : val + 7'd1;
							KEY_MINUS: val = (val == 0) ? FIELD_MAX :
							                 (val > FIELD_OVER) ? FIELD_MAX : val - 7'd1;
							KEY_MODE:  mode_flag = !mode_flag;
							default: ;
						endcase
						// write the edited value back
						if (key == KEY_PLUS || key == KEY_MINUS) begin
							if (field_sel == SEL_SEC) sec_v = val;
							else if (field_sel == SEL_MIN) min_v = val;
							else hour_v = val;
						end
					end
				end
				OP_CLEAR: begin
					sec_v  = '0;
					min_v  = '0;
					hour_v = '0;
				end
				default: ;
			endcase
			// stop at zero and flip the mode
			if (run_flag && sec_v == 0 && min_v == 0 && hour_v == 0) begin
				run_flag    = 1'b0;
				mode_flag   = !mode_flag;
				st.finished = 1'b1;
			end
			st.sec     = sec_v;
			st.min     = min_v;
			st.hour    = hour_v;
			st.running = run_flag;
			st.field   = field_sel;
			st.mode    = mode_flag;
			st.relay   = !mode_flag;
			st.alarm   = run_flag && hour_v == 0 && min_v == 0 && sec_v < warn_reg;
			status_q.push_back(st);
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Match one result word against the oldest queued status
		function void check_result(logic [OUT_W-1:0] word);
			timer_status_t st;
			if (status_q.size() == 0) begin
				$display("%0t: result %h with no request outstanding", $time, word);
				errors++;
				return;
			end
			st = status_q.pop_front();
			compare_field("seconds", 8'(st.sec), 8'(word[SEC_LSB +: 7]));
			compare_field("minutes", 8'(st.min), 8'(word[MIN_LSB +: 7]));
			compare_field("hours", 8'(st.hour), 8'(word[HOUR_LSB +: 7]));
			compare_field("running", 8'(st.running), 8'(word[RUN_BIT]));
			compare_field("selected_field", 8'(st.field), 8'(word[SEL_LSB +: 2]));
			compare_field("mode_led", 8'(st.mode), 8'(word[MODE_BIT]));
			compare_field("relay_on", 8'(st.relay), 8'(word[RELAY_BIT]));
			compare_field("alarm", 8'(st.alarm), 8'(word[ALARM_BIT]));
			compare_field("finished", 8'(st.finished), 8'(word[FINISH_BIT]));
			compare_field("padding", 8'd0, 8'(word[OUT_W-1:FINISH_BIT+1]));
		endfunction
	endclass

	timer_scoreboard sb;

	hms_countdown_timer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drain results with random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Offer one request after a random gap and hold it until taken
	task automatic send_req(logic [1:0] op, logic [3:0] key);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0000, key};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(op, key);
		accepted++;
	endtask

	// Hold off until every result is back and the pipeline is empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Edit a short time, start it and tick until it stops or a random tick budget runs out
	task automatic run_session();
		int         edits;
		int         ticks;
		logic [3:0] k;
		if ($urandom_range(0, 99) < 70) send_req(OP_CLEAR, 4'($urandom_range(0, 15)));
		edits = $urandom_range(0, 6);
		repeat (edits) begin
			case ($urandom_range(0, 9))
				0, 1:    k = KEY_LEFT;
				2:       k = KEY_RIGHT;
				3:       k = KEY_MINUS;
				default: k = KEY_PLUS;
			endcase
			send_req(OP_KEY, k);
		end
		if ($urandom_range(0, 9) == 0) send_req(OP_KEY, KEY_MODE);
		send_req(OP_KEY, KEY_START);
		ticks = $urandom_range(1, 80);
		while (sb.run_flag && ticks > 0) begin
			case ($urandom_range(0, 19))
				0:       send_req(OP_KEY, 4'($urandom_range(0, 15)));
				1:       send_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
				default: send_req(OP_TICK, 4'($urandom_range(0, 15)));
			endcase
			ticks--;
		end
		if (sb.run_flag && $urandom_range(0, 1) == 1) send_req(OP_CLEAR, KEY_NONE);
	endtask

	task automatic run_phase(int budget);
		int first;
		first = accepted;
		while (accepted - first < budget) begin
			if ($urandom_range(0, 99) < 85) run_session();
			else send_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
		end
	endtask

	// Run ceiling
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = CFG_TICKS_PER_SECOND;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_TICK;
		m_axis_tready = 1'b0;
		idle_pct      = 29;
		accepted      = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Editing with reset settings: wraps, selection, ignored codes, zero start
		send_req(OP_TICK, KEY_NONE);
		send_req(OP_KEY, KEY_MINUS);
		send_req(OP_KEY, KEY_PLUS);
		send_req(OP_KEY, KEY_LEFT);
		send_req(OP_KEY, KEY_MINUS);
		send_req(OP_KEY, KEY_LEFT);
		send_req(OP_KEY, KEY_PLUS);
		send_req(OP_KEY, KEY_LEFT);
		send_req(OP_KEY, KEY_RIGHT);
		send_req(OP_KEY, KEY_RIGHT);
		send_req(OP_KEY, KEY_NONE);
		send_req(OP_KEY, KEY_MODE);
		send_req(OP_UNUSED, KEY_MODE);
		send_req(OP_CLEAR, KEY_NONE);
		send_req(OP_KEY, KEY_START);

		// Every tick a second: hour and minute borrow, keys ignored, clear while running
		drain();
		write_reg(CFG_TICKS_PER_SECOND, 8'd1);
		write_reg(CFG_WARNING_SECONDS, 8'd99);
		send_req(OP_KEY, KEY_LEFT);
		send_req(OP_KEY, KEY_PLUS);
		send_req(OP_KEY, KEY_START);
		send_req(OP_TICK, KEY_NONE);
		send_req(OP_KEY, KEY_MODE);
		send_req(OP_TICK, KEY_NONE);
		send_req(OP_CLEAR, KEY_NONE);
		send_req(OP_KEY, KEY_RIGHT);
		send_req(OP_KEY, KEY_PLUS);
		send_req(OP_KEY, KEY_START);
		send_req(OP_TICK, KEY_NONE);
		send_req(OP_CLEAR, KEY_NONE);

		// Random countdown sessions over several settings
		drain();
		write_reg(CFG_WARNING_SECONDS, 8'd5);
		run_phase(20);

		drain();
		idle_pct = 0;
		write_reg(CFG_TICKS_PER_SECOND, 8'd0);
		write_reg(CFG_WARNING_SECONDS, 8'd0);
		run_phase(60);

		drain();
		idle_pct = 29;
		write_reg(CFG_TICKS_PER_SECOND, 8'd2);
		write_reg(CFG_WARNING_SECONDS, 8'd99);
		run_phase(20);

		// Slowest prescale: one full wrap while running
		drain();
		write_reg(CFG_TICKS_PER_SECOND, 8'd255);
		write_reg(CFG_WARNING_SECONDS, 8'd127);
		send_req(OP_CLEAR, KEY_NONE);
		repeat (3) send_req(OP_KEY, KEY_PLUS);
		send_req(OP_KEY, KEY_START);
		repeat (260) send_req(OP_TICK, 4'($urandom_range(0, 15)));
		send_req(OP_CLEAR, KEY_NONE);

		drain();
		write_reg(CFG_TICKS_PER_SECOND, 8'd3);
		write_reg(CFG_WARNING_SECONDS, 8'($urandom_range(0, 99)));
		run_phase(20);

		drain();
		write_reg(CFG_TICKS_PER_SECOND, 8'd1);
		write_reg(CFG_WARNING_SECONDS, 8'd50);
		run_phase(20);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
